// File: rtl/core/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg - host power sequencer shared definitions
// phase codes, configuration register indexes, state and settings types
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned CntW    = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    PH_OFF    = 2'd0,
    PH_WAIT   = 2'd1,
    PH_AWAKE  = 2'd2,
    PH_REBOOT = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ON_TH     = 3'd0,
    REG_OFF_TH    = 3'd1,
    REG_WAKEUP_TH = 3'd2,
    REG_REBOOT_TH = 3'd3
  } cfg_reg_e;

  localparam logic [CntW-1:0] CntMax         = {CntW{1'b1}};
  localparam logic [CntW-1:0] OnThReset      = 32'd60;
  localparam logic [CntW-1:0] OffThReset     = 32'd3600;
  localparam logic [CntW-1:0] WakeupThReset  = 32'd3600;
  localparam logic [CntW-1:0] RebootThReset  = 32'd10;

  typedef struct packed {
    phase_e          phase;
    logic            power;
    logic [CntW-1:0] on_count;
    logic [CntW-1:0] off_count;
    logic [CntW-1:0] reboot_count;
  } seq_state_t;

  typedef struct packed {
    logic [CntW-1:0] on_th;
    logic [CntW-1:0] off_th;
    logic [CntW-1:0] wakeup_th;
    logic [CntW-1:0] reboot_th;
  } seq_cfg_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
  endfunction

endpackage

// File: rtl/core/hps_step.sv
// ----------------------------------------------------------------------------
// hps_step - one tick of the power sequencer
// next phase, supply enable and counters from the current state and a word
// ----------------------------------------------------------------------------
module hps_step (
  input  hps_pkg::seq_state_t cur_i,
  input  hps_pkg::seq_cfg_t   cfg_i,
  input  logic                host_status_i,
  input  logic                force_wake_i,
  output hps_pkg::seq_state_t nxt_o
);

  logic [hps_pkg::CntW-1:0] on_inc;
  logic [hps_pkg::CntW-1:0] off_inc;
  logic [hps_pkg::CntW-1:0] reboot_inc;

  assign on_inc     = hps_pkg::sat_inc(cur_i.on_count);
  assign off_inc    = hps_pkg::sat_inc(cur_i.off_count);
  assign reboot_inc = hps_pkg::sat_inc(cur_i.reboot_count);

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      hps_pkg::PH_OFF: begin
        if (off_inc >= cfg_i.off_th || off_inc >= cfg_i.wakeup_th || force_wake_i) begin
          nxt_o.off_count = '0;
          nxt_o.power     = 1'b1;
          nxt_o.phase     = hps_pkg::PH_WAIT;
        end else begin
          nxt_o.off_count = off_inc;
        end
      end
      hps_pkg::PH_WAIT: begin
        nxt_o.on_count = on_inc;
        if (host_status_i) begin
          nxt_o.phase = hps_pkg::PH_AWAKE;
        end else if (on_inc >= cfg_i.on_th) begin
          nxt_o.on_count = '0;
          nxt_o.power    = 1'b0;
          nxt_o.phase    = hps_pkg::PH_OFF;
        end
      end
      hps_pkg::PH_AWAKE: begin
        if (!host_status_i) begin
          nxt_o.reboot_count = '0;
          nxt_o.on_count     = '0;
          nxt_o.phase        = hps_pkg::PH_REBOOT;
        end else if (on_inc >= cfg_i.on_th) begin
          nxt_o.on_count = '0;
          nxt_o.power    = 1'b0;
          nxt_o.phase    = hps_pkg::PH_OFF;
        end else begin
          nxt_o.on_count = on_inc;
        end
      end
      hps_pkg::PH_REBOOT: begin
        if (reboot_inc >= cfg_i.reboot_th) begin
          nxt_o.reboot_count = '0;
          if (host_status_i) begin
            nxt_o.phase = hps_pkg::PH_AWAKE;
          end else begin
            nxt_o.power = 1'b0;
            nxt_o.phase = hps_pkg::PH_OFF;
          end
        end else begin
          nxt_o.reboot_count = reboot_inc;
        end
      end
      default: nxt_o = cur_i;
    endcase
  end

endmodule

// File: rtl/core/host_power_sequencer_unit.sv
// ----------------------------------------------------------------------------
// host_power_sequencer_unit - tick-driven supply sequencer for a companion host
// drives the host supply enable from its status pin and a force-wake flag
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per tick (host_status_i, force_wake_i), taken at
//   an edge where in_valid_i is high and in_stall_o is low
//   output channel: one word per tick (power_enable_o, phase_o), the supply
//   enable and phase after that tick, taken when out_valid_o is high and
//   out_stall_i is low
//   config channel: cfg_index_i / cfg_data_i written when cfg_valid_i and
//   cfg_ready_o are high; indexes 0..3 are on, off, wakeup and reboot
//   thresholds, anything higher is dropped; write only while idle
// timing
//   a word is registered on acceptance; it is stepped and its result loaded
//   into the result register once that register is free or draining; one
//   word per cycle sustained while out_stall_i stays low
// reset
//   phase wait-on with the supply on, all counters zero, thresholds back to
//   60 / 3600 / 3600 / 10, both pipeline stages empty
// stall
//   a stalled result holds; the input register keeps taking words while the
//   result register is free or draining, and stall goes back to the source
//   only once both stages are full
// ----------------------------------------------------------------------------
module host_power_sequencer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tick words in
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        host_status_i,
  input  logic                        force_wake_i,
  // results out
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        power_enable_o,
  output logic [1:0]                  phase_o,
  // register writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hps_pkg::CntW-1:0]    cfg_data_i
);

  // input register
  logic in_valid_q, in_valid_d;
  logic status_q, force_q;

  // sequencer state and thresholds
  hps_pkg::seq_state_t st_q, st_nxt;
  hps_pkg::seq_cfg_t   cfg_q;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       out_power_q;
  logic [1:0] out_phase_q;

  logic in_take;   // word accepted into the input register
  logic step;      // registered word is stepped and its result loaded

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take | (in_valid_q & ~step);
  assign out_valid_d = step | (out_valid_q & out_stall_i);

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the input stage
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      status_q <= host_status_i;
      force_q  <= force_wake_i;
    end
  end

  // threshold registers, reset to their defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_th     <= hps_pkg::OnThReset;
      cfg_q.off_th    <= hps_pkg::OffThReset;
      cfg_q.wakeup_th <= hps_pkg::WakeupThReset;
      cfg_q.reboot_th <= hps_pkg::RebootThReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hps_pkg::REG_ON_TH:     cfg_q.on_th     <= cfg_data_i;
        hps_pkg::REG_OFF_TH:    cfg_q.off_th    <= cfg_data_i;
        hps_pkg::REG_WAKEUP_TH: cfg_q.wakeup_th <= cfg_data_i;
        hps_pkg::REG_REBOOT_TH: cfg_q.reboot_th <= cfg_data_i;
        default: ;  // indexes past the register list are ignored
      endcase
    end
  end

  // one tick of the phase machine
  hps_step u_step (
    .cur_i         (st_q),
    .cfg_i         (cfg_q),
    .host_status_i (status_q),
    .force_wake_i  (force_q),
    .nxt_o         (st_nxt)
  );

  // sequencer state: wait-on with the supply up after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase        <= hps_pkg::PH_WAIT;
      st_q.power        <= 1'b1;
      st_q.on_count     <= '0;
      st_q.off_count    <= '0;
      st_q.reboot_count <= '0;
    end else if (step) begin
      st_q <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_power_q <= st_nxt.power;
      out_phase_q <= st_nxt.phase;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_enable_o = out_power_q;
  assign phase_o        = out_phase_q;

  // supply is down exactly in the off phase
  a_power_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.power != (st_q.phase == hps_pkg::PH_OFF))
    else $error("supply enable disagrees with phase");

  // a loaded result mirrors the state it was stepped to
  a_result_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (out_power_q == st_q.power) && (out_phase_q == st_q.phase))
    else $error("result register does not match sequencer state");

  // off counter only runs in the off phase
  a_off_count_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase != hps_pkg::PH_OFF |-> st_q.off_count == '0)
    else $error("off counter nonzero outside off phase");

  // entering reboot detect clears the on counter and it stays clear there
  a_reboot_on_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == hps_pkg::PH_REBOOT |-> st_q.on_count == '0)
    else $error("on counter nonzero in reboot detect");

endmodule

// File: sim/host_power_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// host_power_sequencer_unit_tb - self-checking bench for the supply sequencer
// steps a local model of the four-phase sequencer on every accepted tick word,
// checks each result word against it, reprograms thresholds between phases
// ----------------------------------------------------------------------------
module host_power_sequencer_unit_tb;
  import hps_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned DrainCycles = 6;        // result passes the input and result registers after a tick
  localparam int unsigned CycleLimit  = 500000;   // slowest legal run is well under this
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhaseTicks  = 170;
  localparam logic [CfgIdxW-1:0] RegIdxSpareLo = 3'd4;   // first index the block drops
  localparam logic [CfgIdxW-1:0] RegIdxTop     = {CfgIdxW{1'b1}};

  // supply enable and phase after one tick
  typedef struct packed {
    logic   power;
    phase_e phase;
  } tick_result_t;

  // ---------------------------------------------------------------------------
  // sequencer model and result store
  // ---------------------------------------------------------------------------
  class supply_sequence_board;
    seq_cfg_t        th;
    phase_e          ph;
    logic            pwr;
    logic [CntW-1:0] on_cnt;
    logic [CntW-1:0] off_cnt;
    logic [CntW-1:0] rb_cnt;
    tick_result_t    awaited_q[$];
    int unsigned     fault_count;

    function new();
      th.on_th     = OnThReset;
      th.off_th    = OffThReset;
      th.wakeup_th = WakeupThReset;
      th.reboot_th = RebootThReset;
      ph           = PH_WAIT;
      pwr          = 1'b1;
      on_cnt       = '0;
      off_cnt      = '0;
      rb_cnt       = '0;
      fault_count  = 0;
    endfunction

    // counters stick at all-ones
    function logic [CntW-1:0] bump(input logic [CntW-1:0] v);
      return (v == CntMax) ? v : v + 1'b1;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] val);
      case (idx)
        REG_ON_TH:     th.on_th     = val;
        REG_OFF_TH:    th.off_th    = val;
        REG_WAKEUP_TH: th.wakeup_th = val;
        REG_REBOOT_TH: th.reboot_th = val;
        default: ;   // spare indexes are dropped
      endcase
    endfunction

    // one accepted tick word: advance the model and queue the result word
    function void note_tick(input logic status, input logic wake);
      tick_result_t res;
      case (ph)
        PH_OFF: begin
          off_cnt = bump(off_cnt);
          if (off_cnt >= th.off_th || off_cnt >= th.wakeup_th || wake) begin
            off_cnt = '0;
            pwr     = 1'b1;
            ph      = PH_WAIT;
          end
        end
        PH_WAIT: begin
          on_cnt = bump(on_cnt);
          if (status) begin
            ph = PH_AWAKE;
          end else if (on_cnt >= th.on_th) begin
            on_cnt = '0;
            pwr    = 1'b0;
            ph     = PH_OFF;
          end
        end
        PH_AWAKE: begin
          if (!status) begin
            rb_cnt = '0;
            on_cnt = '0;
            ph     = PH_REBOOT;
          end else begin
            on_cnt = bump(on_cnt);
            if (on_cnt >= th.on_th) begin
              on_cnt = '0;
              pwr    = 1'b0;
              ph     = PH_OFF;
            end
          end
        end
        default: begin
          rb_cnt = bump(rb_cnt);
          if (rb_cnt >= th.reboot_th) begin
            rb_cnt = '0;
            if (status) begin
              ph = PH_AWAKE;
            end else begin
              pwr = 1'b0;
              ph  = PH_OFF;
            end
          end
        end
      endcase
      res.power = pwr;
      res.phase = ph;
      awaited_q.push_back(res);
    endfunction

    function void flag(input string what, input int unsigned exp_v, input int unsigned got_v);
      fault_count++;
      if (fault_count <= MaxReports)
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    endfunction

    // one accepted result word against the oldest expectation
    function void check_tick(input logic got_power, input logic [1:0] got_phase);
      tick_result_t exp_r;
      if (awaited_q.size() == 0) begin
        flag("result word with none outstanding, phase", 0, got_phase);
        return;
      end
      exp_r = awaited_q.pop_front();
      if (got_power !== exp_r.power) flag("power_enable", exp_r.power, got_power);
      if (got_phase !== exp_r.phase) flag("phase", exp_r.phase, got_phase);
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block ports
  // ---------------------------------------------------------------------------
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               host_status_i = 1'b0;
  logic               force_wake_i  = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               power_enable_o;
  logic [1:0]         phase_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [CntW-1:0]    cfg_data_i    = '0;

  supply_sequence_board board;
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned stall_left   = 0;

  host_power_sequencer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .host_status_i  (host_status_i),
    .force_wake_i   (force_wake_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_enable_o (power_enable_o),
    .phase_o        (phase_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: sampled straight after the edge, so these are pre-edge values
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_tick(host_status_i, force_wake_i);
      if (out_valid_o && !out_stall_i) board.check_tick(power_enable_o, phase_o);
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // result side back-pressure, held in random bursts
  always @(posedge clk_i) begin
    if (stall_left == 0 && sink_idle_on && $urandom_range(2) == 0) stall_left = idle_len();
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on the cycle count
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one tick word; valid only drops when a gap is taken, so it never toggles in one step
  task automatic send_tick(input logic status, input logic wake);
    int unsigned gap;
    gap = src_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    host_status_i <= status;
    force_wake_i  <= wake;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending and let every outstanding result word drain
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no toggle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // all four thresholds plus a stray write to a spare index
  task automatic set_thresholds(input logic [CntW-1:0] on_v, input logic [CntW-1:0] off_v,
                                input logic [CntW-1:0] wake_v, input logic [CntW-1:0] rb_v);
    write_reg(CfgIdxW'($urandom_range(RegIdxTop, RegIdxSpareLo)), $urandom());
    write_reg(REG_ON_TH, on_v);
    write_reg(REG_OFF_TH, off_v);
    write_reg(REG_WAKEUP_TH, wake_v);
    write_reg(REG_REBOOT_TH, rb_v);
    cfg_valid_i <= 1'b0;
  endtask

  // threshold for mixed settings: zero, one, short, saturated or anything
  function automatic logic [CntW-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 1;
      4:       return CntMax;
      5:       return $urandom();
      default: return $urandom_range(12, 2);
    endcase
  endfunction

  // status held level in runs so the host stays up or down long enough to
  // reach the on limit, a full reboot window or a reboot that recovers;
  // a fraction of runs toggle at random, force-wake is rare noise
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned burst;
    int unsigned k;
    logic        level;
    bit          steady;
    sent = 0;
    while (sent < n) begin
      burst  = ($urandom_range(7) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
      level  = $urandom_range(1) != 0;
      steady = $urandom_range(4) != 0;
      for (k = 0; k < burst && sent < n; k++) begin
        send_tick(steady ? level : ($urandom_range(1) != 0), $urandom_range(23) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned p;
    board = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: force-wake ignored while waiting, awake and in reboot
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    // short thresholds: reboot window expires, off by count, force-wake, on limit
    set_thresholds(2, 3, 5, 1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    settle();

    // zero thresholds are met on the first tick of every phase
    set_thresholds('0, '0, '0, '0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();

    // saturated thresholds: reboot window never closes
    set_thresholds(CntMax, CntMax, CntMax, CntMax);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    settle();

    // random phases, each with its own thresholds and idling mix
    for (p = 0; p < PhaseCount; p++) begin
      if (p == 0)
        set_thresholds('0, '0, '0, '0);
      else if (p == 1)
        set_thresholds(CntMax, CntMax, CntMax, CntMax);
      else if (p == 2)
        set_thresholds(OnThReset, OffThReset, WakeupThReset, RebootThReset);
      else if (p[0])
        set_thresholds($urandom_range(6), $urandom_range(6), $urandom_range(6),
                       $urandom_range(6));
      else
        set_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                       pick_threshold());
      src_idle_on  = $urandom_range(3) != 0;
      sink_idle_on = $urandom_range(3) != 0;
      run_random(PhaseTicks);
      settle();
    end

    if (board.fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hps_pkg.sv
rtl/core/hps_step.sv
rtl/core/host_power_sequencer_unit.sv
sim/host_power_sequencer_unit_tb.sv
